[hdl/crc_chained_hash_table_macros.svh]
// Assertion helpers for the checker of the hash table.
`ifndef CRC_CHAINED_HASH_TABLE_MACROS_SVH
`define CRC_CHAINED_HASH_TABLE_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define CRCHT_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("crcht checker: property failed");

// Next-cycle implication, sampled on clk and disabled during reset.
`define CRCHT_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("crcht checker: property failed");

`endif

[hdl/crcht_pkg.sv]
package crcht_pkg;

	// Table dimensions.
	localparam int NUM_BUCKETS   = 256;
	localparam int NUM_ENTRIES   = 256;
	localparam int MAX_KEY_BYTES = 32;
	localparam int KEY_SLOTS     = MAX_KEY_BYTES / 4;

	localparam int BKT_W   = $clog2(NUM_BUCKETS);
	localparam int IDX_W   = $clog2(NUM_ENTRIES);
	localparam int PTR_W   = IDX_W + 1;
	localparam int SLOT_W  = $clog2(KEY_SLOTS);
	localparam int SCNT_W  = SLOT_W + 1;
	localparam int LEN_W   = $clog2(MAX_KEY_BYTES) + 1;
	localparam int KADDR_W = IDX_W + SLOT_W;

	// Field widths of the channels.
	localparam int REQ_W    = 2;
	localparam int CHUNK_W  = 32;
	localparam int NB_W     = 3;
	localparam int VAL_W    = 32;
	localparam int STATUS_W = 3;
	localparam int COUNT_W  = 9;
	localparam int LV_W     = LEN_W + VAL_W;

	localparam logic [PTR_W-1:0] NIL = PTR_W'(NUM_ENTRIES);
	localparam logic [31:0] CRC_POLY = 32'h04C1_1DB7;
	localparam logic [LEN_W-1:0] LAST_WORD_LEN = LEN_W'(MAX_KEY_BYTES - 4);

	// Request codes; any other code behaves as a lookup.
	typedef enum logic [REQ_W-1:0] {
		REQ_INSERT = 2'd0,
		REQ_DELETE = 2'd1,
		REQ_GET    = 2'd2,
		REQ_GET_ALT = 2'd3
	} req_t;

	typedef enum logic [STATUS_W-1:0] {
		RS_INSERTED  = 3'd0,
		RS_UPDATED   = 3'd1,
		RS_DELETED   = 3'd2,
		RS_DEL_MISS  = 3'd3,
		RS_FOUND     = 3'd4,
		RS_FIND_MISS = 3'd5,
		RS_FULL      = 3'd6,
		RS_KEY_LONG  = 3'd7
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE, S_CRC, S_OP, S_HEAD, S_CHECK, S_CMP, S_ALLOC, S_ALLOC_WAIT,
		S_COPY, S_LINK1, S_LINK2, S_DEL1, S_DEL2, S_FINISH
	} state_t;

	// Eight steps of the non-reflected CRC division, feeding one data byte msb first.
	function automatic logic [31:0] crc_byte(input logic [31:0] h, input logic [7:0] b);
		logic [31:0] r;
		logic top;
		r = h;
		for (int i = 7; i >= 0; i--) begin
			top = r[31];
			r = {r[30:0], b[i]};
			if (top) begin
				r = r ^ CRC_POLY;
			end
		end
		return r;
	endfunction

endpackage

[hdl/crcht_ifs.sv]
// Request channel: one key chunk per item.
interface crcht_req_if;
	import crcht_pkg::*;
	logic                valid;
	logic                ready;
	logic [REQ_W-1:0]    req_type;
	logic [CHUNK_W-1:0]  key_chunk;
	logic [NB_W-1:0]     chunk_bytes;
	logic                last_chunk;
	logic [VAL_W-1:0]    value_in;

	modport source (output valid, req_type, key_chunk, chunk_bytes, last_chunk, value_in,
		input ready);
	modport sink (input valid, req_type, key_chunk, chunk_bytes, last_chunk, value_in,
		output ready);
endinterface

// Response channel: one item per completed operation.
interface crcht_rsp_if;
	import crcht_pkg::*;
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [VAL_W-1:0]    value_out;
	logic [COUNT_W-1:0]  entry_count;

	modport source (output valid, status, value_out, entry_count, input ready);
	modport sink (input valid, status, value_out, entry_count, output ready);
endinterface

[hdl/crcht_ram.sv]
module crcht_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[hdl/crc_chained_hash_table.sv]
// Chained hash table with key hashing by the CRC-32 polynomial (non-reflected).
// A key arrives on the req channel as a run of items: an optional first item of
// 1 to 3 prefix bytes, then 4-byte words. The item with last_chunk set performs
// req_type (insert/update, delete, get) and produces exactly one rsp item with
// status, value_out and entry_count; other items produce none.
// A 4-byte word is accepted and then fed to the CRC unit in four byte steps;
// a prefix or empty chunk is taken without CRC steps. An operation then reads
// the bucket head and walks the chain, comparing the length and key words of
// each entry visited (key memory read port, one word a cycle), then copies the
// key and links a new entry or unlinks a deleted one, and hands over the result.
// The result sits in an output register; while it waits for rsp.ready, further
// key chunks are still accepted, and only the next completed operation waits.
// bucket_count_log2 is written over the APB port at addresses 0 to 3 (read back
// at address 0); the user must do so only while idle, the block does not enforce it.
// Reset (arst_n low) empties every chain at once by clearing the bucket valid
// bits, empties the free list, zeroes the entry count and drops any part key.
module crc_chained_hash_table (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	crcht_req_if.sink   req,
	crcht_rsp_if.source rsp
);

	import crcht_pkg::*;

	state_t state_q, state_d;

	logic [3:0]               cfg_log2_q;
	logic [31:0]              crc_h_q;
	logic [31:0]              crc_d_q;
	logic [1:0]               crc_cnt_q;
	logic                     last_pend_q;
	logic [LEN_W-1:0]         len_q;
	logic [SCNT_W-1:0]        slots_q;
	logic                     ovf_q;
	logic [31:0]              req_key_q [KEY_SLOTS];
	logic [REQ_W-1:0]         op_q;
	logic [VAL_W-1:0]         val_q;
	logic [BKT_W-1:0]         bucket_q;
	logic [PTR_W-1:0]         cur_q;
	logic [PTR_W-1:0]         prev_q;
	logic [PTR_W-1:0]         nxt_q;
	logic [PTR_W-1:0]         e_q;
	logic [SLOT_W-1:0]        widx_q;
	logic [PTR_W-1:0]         free_q;
	logic [PTR_W-1:0]         never_q;
	logic [COUNT_W-1:0]       count_q;
	logic [NUM_BUCKETS-1:0]   head_vld_q;
	status_t                  res_status_q;
	logic [VAL_W-1:0]         res_value_q;
	logic                     out_vld_q;
	status_t                  out_status_q;
	logic [VAL_W-1:0]         out_value_q;
	logic [COUNT_W-1:0]       out_count_q;

	// Memory ports.
	logic                 head_we, next_we, lv_we, key_we;
	logic [BKT_W-1:0]     head_waddr, head_raddr;
	logic [PTR_W-1:0]     head_wdata, head_rd;
	logic [IDX_W-1:0]     next_waddr, next_raddr, lv_waddr, lv_raddr;
	logic [PTR_W-1:0]     next_wdata, next_rd;
	logic [LV_W-1:0]      lv_wdata, lv_rd;
	logic [KADDR_W-1:0]   key_waddr, key_raddr;
	logic [31:0]          key_wdata, key_rd;

	logic                 accept, out_free, cfg_wr;
	logic [BKT_W-1:0]     bucket_sel;
	logic [BKT_W-1:0]     mask8;
	logic [31:0]          prefix_mask;
	logic                 len_ok, word_ok, last_word, cmp_hit, cmp_step;
	logic                 is_ins, is_del;

	assign accept   = req.valid && req.ready;
	assign req.ready = (state_q == S_IDLE);
	assign out_free = !out_vld_q || rsp.ready;
	assign is_ins   = (op_q == REQ_INSERT);
	assign is_del   = (op_q == REQ_DELETE);

	// Configuration port.
	assign cfg_wr = psel && penable && pwrite && pready;
	assign pready = 1'b1;
	assign prdata = (paddr == 3'd0) ? {28'd0, cfg_log2_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_log2_q <= 4'd8;
		end else if (cfg_wr && !paddr[2]) begin
			cfg_log2_q <= pwdata[3:0];
		end
	end

	// Bucket index from the hash and the bucket count in use.
	assign mask8 = (cfg_log2_q >= 4'd8) ? '1 : BKT_W'((9'd1 << cfg_log2_q[2:0]) - 9'd1);
	assign bucket_sel = crc_h_q[BKT_W-1:0] & mask8;

	always_comb begin
		case (req.chunk_bytes[1:0])
			2'd1:    prefix_mask = 32'h0000_00FF;
			2'd2:    prefix_mask = 32'h0000_FFFF;
			2'd3:    prefix_mask = 32'h00FF_FFFF;
			default: prefix_mask = 32'h0000_0000;
		endcase
	end

	// Key comparison against the entry being visited.
	assign len_ok    = (lv_rd[LV_W-1:VAL_W] == len_q);
	assign word_ok   = (key_rd == req_key_q[widx_q]);
	assign last_word = ({1'b0, widx_q} + SCNT_W'(1)) == slots_q;
	assign cmp_hit   = len_ok && ((slots_q == '0) || (word_ok && last_word));
	assign cmp_step  = !len_ok || ((slots_q != '0) && !word_ok);

	// Next state and memory port control.
	always_comb begin
		state_d    = state_q;
		head_we    = 1'b0;
		head_waddr = bucket_q;
		head_wdata = e_q;
		head_raddr = bucket_sel;
		next_we    = 1'b0;
		next_waddr = e_q[IDX_W-1:0];
		next_wdata = NIL;
		next_raddr = cur_q[IDX_W-1:0];
		lv_we      = 1'b0;
		lv_waddr   = cur_q[IDX_W-1:0];
		lv_wdata   = {len_q, val_q};
		lv_raddr   = cur_q[IDX_W-1:0];
		key_we     = 1'b0;
		key_waddr  = {e_q[IDX_W-1:0], widx_q};
		key_wdata  = req_key_q[widx_q];
		key_raddr  = {cur_q[IDX_W-1:0], SLOT_W'(0)};
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (req.chunk_bytes[2] && !ovf_q && len_q <= LAST_WORD_LEN) begin
						state_d = S_CRC;
					end else if (req.last_chunk) begin
						state_d = S_OP;
					end
				end
			end
			S_CRC: begin
				if (crc_cnt_q == 2'd3) begin
					state_d = last_pend_q ? S_OP : S_IDLE;
				end
			end
			S_OP: begin
				state_d = ovf_q ? S_FINISH : S_HEAD;
			end
			S_HEAD: begin
				state_d = S_CHECK;
			end
			S_CHECK: begin
				if (cur_q == NIL) begin
					if (is_ins && free_q != NIL) begin
						state_d = S_ALLOC;
					end else if (is_ins && never_q != NIL) begin
						state_d = S_COPY;
					end else begin
						state_d = S_FINISH;
					end
				end else begin
					state_d = S_CMP;
				end
			end
			S_CMP: begin
				key_raddr = {cur_q[IDX_W-1:0], widx_q + SLOT_W'(1)};
				if (cmp_step) begin
					state_d = S_CHECK;
				end else if (cmp_hit) begin
					if (is_ins) begin
						lv_we   = 1'b1;
						state_d = S_FINISH;
					end else if (is_del) begin
						state_d = S_DEL1;
					end else begin
						state_d = S_FINISH;
					end
				end
			end
			S_ALLOC: begin
				next_raddr = free_q[IDX_W-1:0];
				state_d    = S_ALLOC_WAIT;
			end
			S_ALLOC_WAIT: begin
				state_d = S_COPY;
			end
			S_COPY: begin
				if (slots_q == '0) begin
					state_d = S_LINK1;
				end else begin
					key_we = 1'b1;
					if (last_word) begin
						state_d = S_LINK1;
					end
				end
			end
			S_LINK1: begin
				lv_we    = 1'b1;
				lv_waddr = e_q[IDX_W-1:0];
				next_we  = 1'b1;
				if (prev_q == NIL) begin
					head_we = 1'b1;
					state_d = S_FINISH;
				end else begin
					state_d = S_LINK2;
				end
			end
			S_LINK2: begin
				next_we    = 1'b1;
				next_waddr = prev_q[IDX_W-1:0];
				next_wdata = e_q;
				state_d    = S_FINISH;
			end
			S_DEL1: begin
				if (prev_q == NIL) begin
					head_we    = 1'b1;
					head_wdata = nxt_q;
				end else begin
					next_we    = 1'b1;
					next_waddr = prev_q[IDX_W-1:0];
					next_wdata = nxt_q;
				end
				state_d = S_DEL2;
			end
			S_DEL2: begin
				next_we    = 1'b1;
				next_waddr = cur_q[IDX_W-1:0];
				next_wdata = free_q;
				state_d    = S_FINISH;
			end
			S_FINISH: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Control state: request progress, pool pointers, count, valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q       <= '0;
			slots_q     <= '0;
			ovf_q       <= 1'b0;
			crc_h_q     <= '0;
			crc_cnt_q   <= '0;
			last_pend_q <= 1'b0;
			widx_q      <= '0;
			free_q      <= NIL;
			never_q     <= '0;
			count_q     <= '0;
			head_vld_q  <= '0;
			out_vld_q   <= 1'b0;
		end else begin
			if (head_we) begin
				head_vld_q[bucket_q] <= 1'b1;
			end
			// The output register fills as an operation finishes and empties when taken.
			if (state_q == S_FINISH && out_free) begin
				out_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (req.chunk_bytes[2]) begin
							if (!ovf_q && len_q <= LAST_WORD_LEN) begin
								len_q       <= len_q + LEN_W'(4);
								slots_q     <= slots_q + SCNT_W'(1);
								crc_cnt_q   <= '0;
								last_pend_q <= req.last_chunk;
							end else begin
								ovf_q <= 1'b1;
							end
						end else if (req.chunk_bytes[1:0] != 2'd0 && len_q == '0 && !ovf_q) begin
							len_q   <= LEN_W'(req.chunk_bytes[1:0]);
							slots_q <= SCNT_W'(1);
							crc_h_q <= req.key_chunk & prefix_mask;
						end
					end
				end
				S_CRC: begin
					crc_h_q   <= crc_byte(crc_h_q, crc_d_q[31:24]);
					crc_cnt_q <= crc_cnt_q + 2'd1;
				end
				S_CHECK: begin
					widx_q <= '0;
					if (cur_q == NIL && is_ins && free_q == NIL && never_q != NIL) begin
						never_q <= never_q + PTR_W'(1);
					end
				end
				S_CMP: begin
					if (cmp_step) begin
						widx_q <= '0;
					end else if (!cmp_hit) begin
						widx_q <= widx_q + SLOT_W'(1);
					end
				end
				S_ALLOC_WAIT: begin
					free_q <= next_rd;
					widx_q <= '0;
				end
				S_COPY: begin
					widx_q <= widx_q + SLOT_W'(1);
				end
				S_LINK1: begin
					count_q <= count_q + COUNT_W'(1);
				end
				S_DEL2: begin
					free_q  <= cur_q;
					count_q <= count_q - COUNT_W'(1);
				end
				S_FINISH: begin
					if (out_free) begin
						len_q     <= '0;
						slots_q   <= '0;
						ovf_q     <= 1'b0;
						crc_h_q   <= '0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Payload registers: key words, pointers of the walk, result.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					op_q  <= req.req_type;
					val_q <= req.value_in;
					crc_d_q <= req.key_chunk;
					if (req.chunk_bytes[2] && !ovf_q && len_q <= LAST_WORD_LEN) begin
						req_key_q[slots_q[SLOT_W-1:0]] <= req.key_chunk;
					end else if (req.chunk_bytes[1:0] != 2'd0 && len_q == '0 && !ovf_q) begin
						req_key_q[0] <= req.key_chunk & prefix_mask;
					end
				end
			end
			S_CRC: begin
				crc_d_q <= {crc_d_q[23:0], 8'd0};
			end
			S_OP: begin
				bucket_q     <= bucket_sel;
				prev_q       <= NIL;
				res_status_q <= RS_KEY_LONG;
				res_value_q  <= '0;
			end
			S_HEAD: begin
				cur_q <= head_vld_q[bucket_q] ? head_rd : NIL;
			end
			S_CHECK: begin
				if (cur_q == NIL) begin
					e_q <= never_q;
					if (is_ins) begin
						res_status_q <= RS_FULL;
						res_value_q  <= '0;
					end else if (is_del) begin
						res_status_q <= RS_DEL_MISS;
						res_value_q  <= '0;
					end else begin
						res_status_q <= RS_FIND_MISS;
						res_value_q  <= '1;
					end
				end
			end
			S_CMP: begin
				if (cmp_step) begin
					prev_q <= cur_q;
					cur_q  <= next_rd;
				end else if (cmp_hit) begin
					nxt_q <= next_rd;
					if (is_ins) begin
						res_status_q <= RS_UPDATED;
						res_value_q  <= '0;
					end else if (is_del) begin
						res_status_q <= RS_DELETED;
						res_value_q  <= '0;
					end else begin
						res_status_q <= RS_FOUND;
						res_value_q  <= lv_rd[VAL_W-1:0];
					end
				end
			end
			S_ALLOC_WAIT: begin
				e_q <= free_q;
			end
			S_LINK1: begin
				res_status_q <= RS_INSERTED;
				res_value_q  <= '0;
			end
			S_FINISH: begin
				if (out_free) begin
					out_status_q <= res_status_q;
					out_value_q  <= res_value_q;
					out_count_q  <= count_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign rsp.valid       = out_vld_q;
	assign rsp.status      = out_status_q;
	assign rsp.value_out   = out_value_q;
	assign rsp.entry_count = out_count_q;

	// Chain heads, links, length and value, and key words.
	crcht_ram #(.WIDTH(PTR_W), .DEPTH(NUM_BUCKETS)) u_head_ram (
		.clk(clk), .we(head_we), .waddr(head_waddr), .wdata(head_wdata),
		.raddr(head_raddr), .rdata(head_rd)
	);

	crcht_ram #(.WIDTH(PTR_W), .DEPTH(NUM_ENTRIES)) u_next_ram (
		.clk(clk), .we(next_we), .waddr(next_waddr), .wdata(next_wdata),
		.raddr(next_raddr), .rdata(next_rd)
	);

	crcht_ram #(.WIDTH(LV_W), .DEPTH(NUM_ENTRIES)) u_lv_ram (
		.clk(clk), .we(lv_we), .waddr(lv_waddr), .wdata(lv_wdata),
		.raddr(lv_raddr), .rdata(lv_rd)
	);

	crcht_ram #(.WIDTH(32), .DEPTH(NUM_ENTRIES * KEY_SLOTS)) u_key_ram (
		.clk(clk), .we(key_we), .waddr(key_waddr), .wdata(key_wdata),
		.raddr(key_raddr), .rdata(key_rd)
	);

endmodule

[hdl/crcht_checker.sv]
`include "crc_chained_hash_table_macros.svh"

module crcht_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          rsp_valid,
	input logic                          rsp_ready,
	input logic [crcht_pkg::STATUS_W-1:0] status,
	input logic [crcht_pkg::VAL_W-1:0]    value_out,
	input logic [crcht_pkg::COUNT_W-1:0]  entry_count
);

	import crcht_pkg::*;

	// A stalled result holds.
	`CRCHT_ASSERT_NEXT(rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(status) && $stable(value_out) && $stable(entry_count))

	// A lookup miss answers all ones.
	`CRCHT_ASSERT_NOW(miss_all_ones, rsp_valid && status == RS_FIND_MISS, value_out == '1)

	// Only a lookup carries a value.
	`CRCHT_ASSERT_NOW(value_zero, rsp_valid && status != RS_FOUND && status != RS_FIND_MISS, value_out == '0)

	// The pool never holds more keys than entries.
	`CRCHT_ASSERT_NOW(count_bound, rsp_valid, entry_count <= COUNT_W'(NUM_ENTRIES))

endmodule

bind crc_chained_hash_table crcht_checker u_crcht_checker (
	.clk(clk),
	.arst_n(arst_n),
	.rsp_valid(rsp.valid),
	.rsp_ready(rsp.ready),
	.status(rsp.status),
	.value_out(rsp.value_out),
	.entry_count(rsp.entry_count)
);

[tb/sv/tb_crc_chained_hash_table.sv]
module tb_crc_chained_hash_table;
	import crcht_pkg::*;

	localparam int NILP = NUM_ENTRIES;
	localparam int STALL_LIMIT = 20000;
	localparam int HOLD_CYCLES = 400;

	typedef struct {
		req_t        op;
		logic [31:0] chunk;
		logic [2:0]  nb;
		logic        last;
		logic [31:0] val;
	} chunk_t;

	typedef struct {
		status_t     st;
		logic [31:0] vo;
		logic [8:0]  cnt;
	} answer_t;

	typedef struct {
		int          npre;
		logic [31:0] pre;
		int          nw;
		logic [31:0] w[9];
	} key_t;

	typedef struct {
		chunk_t  c;
		bit      typed;
		answer_t a;
	} row_t;

	logic clk = 0;
	logic arst_n = 0;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	crcht_req_if req_ch();
	crcht_rsp_if rsp_ch();

	crc_chained_hash_table DUT (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
		.req(req_ch), .rsp(rsp_ch)
	);

	always #5 clk = ~clk;

	// Shadow copy of the table.
	int          tbl_head[NUM_BUCKETS];
	int          tbl_next[NUM_ENTRIES];
	logic [7:0]  tbl_key[NUM_ENTRIES][MAX_KEY_BYTES];
	int          tbl_len[NUM_ENTRIES];
	logic [31:0] tbl_val[NUM_ENTRIES];
	int          tbl_free, tbl_fresh, tbl_count, tbl_log2;
	logic [7:0]  pend_key[MAX_KEY_BYTES];
	int          pend_len;
	bit          pend_long;
	logic [63:0] pend_crc;

	answer_t answers_due[$];
	int      mismatches = 0;
	bit      quiet = 0;
	bit      hold_go = 0;
	bit      hold_done = 0;
	int      hold_left = 0;
	key_t    key_pool[$];

	// Folds one chunk into the pending key; returns 1 with the answer on a last chunk.
	function automatic bit table_step(input chunk_t c, output answer_t a);
		int nb, bkt, prev, cur, e;
		bit hit, top;
		nb = (c.nb > 4) ? 4 : c.nb;
		a.st = RS_INSERTED;
		a.vo = '0;
		if (nb != 0 && nb < 4) begin
			if (pend_len == 0 && !pend_long) begin
				for (int i = 0; i < nb; i++) pend_key[i] = 8'(c.chunk >> (8 * (nb - 1 - i)));
				pend_len = nb;
				pend_crc = {32'(c.chunk & ((64'd1 << (8 * nb)) - 1)), 32'd0};
			end
		end else if (nb == 4) begin
			if (pend_long || pend_len + 4 > MAX_KEY_BYTES) begin
				pend_long = 1;
			end else begin
				for (int i = 0; i < 4; i++) pend_key[pend_len + i] = 8'(c.chunk >> (8 * i));
				pend_len += 4;
				pend_crc |= {32'd0, c.chunk};
				for (int i = 0; i < 32; i++) begin
					top = pend_crc[63];
					pend_crc = pend_crc << 1;
					if (top) pend_crc[63:32] ^= CRC_POLY;
				end
			end
		end
		if (!c.last) return 0;
		if (pend_long) begin
			a.st = RS_KEY_LONG;
		end else begin
			bkt = (pend_crc[63:32] & ((32'd1 << tbl_log2) - 1)) % NUM_BUCKETS;
			prev = NILP;
			cur = tbl_head[bkt];
			while (cur < NILP) begin
				hit = (tbl_len[cur] == pend_len);
				for (int i = 0; i < pend_len; i++)
					if (tbl_key[cur][i] != pend_key[i]) hit = 0;
				if (hit) break;
				prev = cur;
				cur = tbl_next[cur];
			end
			if (c.op == REQ_INSERT) begin
				if (cur < NILP) begin
					tbl_val[cur] = c.val;
					a.st = RS_UPDATED;
				end else begin
					if (tbl_free < NILP) begin
						e = tbl_free;
						tbl_free = tbl_next[e];
					end else if (tbl_fresh < NILP) begin
						e = tbl_fresh++;
					end else begin
						e = NILP;
					end
					if (e == NILP) begin
						a.st = RS_FULL;
					end else begin
						for (int i = 0; i < pend_len; i++) tbl_key[e][i] = pend_key[i];
						tbl_len[e] = pend_len;
						tbl_val[e] = c.val;
						tbl_next[e] = NILP;
						if (prev < NILP) tbl_next[prev] = e;
						else tbl_head[bkt] = e;
						tbl_count++;
						a.st = RS_INSERTED;
					end
				end
			end else if (c.op == REQ_DELETE) begin
				if (cur < NILP) begin
					if (prev < NILP) tbl_next[prev] = tbl_next[cur];
					else tbl_head[bkt] = tbl_next[cur];
					tbl_next[cur] = tbl_free;
					tbl_free = cur;
					tbl_count--;
					a.st = RS_DELETED;
				end else begin
					a.st = RS_DEL_MISS;
				end
			end else if (cur < NILP) begin
				a.vo = tbl_val[cur];
				a.st = RS_FOUND;
			end else begin
				a.vo = '1;
				a.st = RS_FIND_MISS;
			end
		end
		a.cnt = 9'(tbl_count);
		pend_len = 0;
		pend_long = 0;
		pend_crc = '0;
		return 1;
	endfunction

	// Offers one item, with random gaps, and records its answer once accepted.
	task automatic offer(input chunk_t c, input bit typed, input answer_t ta);
		answer_t a;
		while (!quiet && $urandom_range(99) < 23) begin
			req_ch.valid <= 0;
			@(posedge clk);
		end
		req_ch.valid <= 1;
		req_ch.req_type <= c.op;
		req_ch.key_chunk <= c.chunk;
		req_ch.chunk_bytes <= c.nb;
		req_ch.last_chunk <= c.last;
		req_ch.value_in <= c.val;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		if (table_step(c, a)) answers_due.push_back(typed ? ta : a);
	endtask

	function automatic key_t random_key();
		key_t k;
		k.npre = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 3);
		k.pre = $urandom;
		k.nw = ($urandom_range(15) == 0) ? $urandom_range(7, 9) : $urandom_range(0, 3);
		for (int i = 0; i < 9; i++) k.w[i] = ($urandom_range(3) == 0) ? $urandom_range(3) : $urandom;
		return k;
	endfunction

	// Sends a whole key, with occasional empty, oversized and late prefix chunks.
	task automatic send_key(input key_t k, input req_t op, input logic [31:0] v);
		chunk_t c;
		answer_t none;
		chunk_t seq[$];
		c.op = op;
		c.val = v;
		c.last = 0;
		if (k.npre > 0) begin
			c.chunk = k.pre;
			c.nb = 3'(k.npre);
			seq.push_back(c);
		end
		for (int i = 0; i < k.nw; i++) begin
			if ($urandom_range(19) == 0) begin
				c.chunk = $urandom;
				c.nb = 0;
				seq.push_back(c);
			end
			c.chunk = k.w[i];
			c.nb = ($urandom_range(7) == 0) ? 3'($urandom_range(4, 7)) : 3'd4;
			seq.push_back(c);
			if ($urandom_range(19) == 0) begin
				c.chunk = $urandom;
				c.nb = 3'($urandom_range(1, 3));
				seq.push_back(c);
			end
		end
		if (seq.size() == 0) begin
			c.chunk = $urandom;
			c.nb = 0;
			seq.push_back(c);
		end
		seq[$].last = 1;
		foreach (seq[i]) offer(seq[i], 0, none);
	endtask

	task automatic random_ops(input int n_items);
		int sent;
		key_t k;
		req_t op;
		sent = 0;
		while (sent < n_items) begin
			k = ($urandom_range(4) == 0 || key_pool.size() == 0) ? random_key()
				: key_pool[$urandom_range(key_pool.size() - 1)];
			case ($urandom_range(9))
				0, 1, 2, 3: op = REQ_INSERT;
				4, 5:       op = REQ_DELETE;
				6, 7, 8:    op = REQ_GET;
				default:    op = REQ_GET_ALT;
			endcase
			send_key(k, op, $urandom);
			sent += (k.npre > 0) + k.nw + ((k.npre + k.nw) == 0);
		end
	endtask

	task automatic apb_cycle(input bit wr, input logic [31:0] d, output logic [31:0] rd);
		psel <= 1;
		penable <= 0;
		pwrite <= wr;
		paddr <= '0;
		pwdata <= d;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		rd = prdata;
		psel <= 0;
		penable <= 0;
	endtask

	// Sets the bucket count once every answer is in, then reads it back.
	task automatic set_buckets(input int lg);
		logic [31:0] rd;
		req_ch.valid <= 0;
		wait (answers_due.size() == 0);
		repeat (40) @(posedge clk);
		apb_cycle(1, lg, rd);
		tbl_log2 = lg;
		@(posedge clk);
		apb_cycle(0, '0, rd);
		if (rd[3:0] != lg) begin
			mismatches++;
			if (mismatches <= 10) $display("bucket_count_log2 read %0d, wrote %0d", rd[3:0], lg);
		end
	endtask

	function automatic row_t row(input req_t op, input logic [31:0] ch, input logic [2:0] nb,
			input logic last, input logic [31:0] v, input bit typed,
			input status_t st, input logic [31:0] vo, input logic [8:0] cnt);
		row_t r;
		r.c = '{op, ch, nb, last, v};
		r.typed = typed;
		r.a = '{st, vo, cnt};
		return r;
	endfunction

	// Receiver: random back-pressure, one long hold-off on request, and the checks.
	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (answers_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("result with no item waiting: status %0d",
					rsp_ch.status);
			end else begin
				answer_t a;
				a = answers_due.pop_front();
				if (rsp_ch.status !== a.st || rsp_ch.value_out !== a.vo
						|| rsp_ch.entry_count !== a.cnt) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result mismatch: got %0d/%h/%0d, wanted %0d/%h/%0d",
							rsp_ch.status, rsp_ch.value_out, rsp_ch.entry_count,
							a.st, a.vo, a.cnt);
				end
			end
		end
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			rsp_ch.ready <= 0;
		end else if (hold_go && !hold_done) begin
			hold_done <= 1;
			hold_left <= HOLD_CYCLES;
			rsp_ch.ready <= 0;
		end else begin
			rsp_ch.ready <= quiet || ($urandom_range(99) >= 23);
		end
	end

	// Watchdog on cycles without any accepted item, taken result or APB access.
	int idle_cycles = 0;
	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || psel)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("tb_crc_chained_hash_table: errors");
			$finish;
		end
	end

	initial begin
		row_t rows[$];
		logic [31:0] rd;
		key_t k;
		req_ch.valid = 0;
		req_ch.req_type = REQ_INSERT;
		req_ch.key_chunk = '0;
		req_ch.chunk_bytes = '0;
		req_ch.last_chunk = 0;
		req_ch.value_in = '0;
		foreach (tbl_head[i]) tbl_head[i] = NILP;
		tbl_free = NILP;
		tbl_fresh = 0;
		tbl_count = 0;
		tbl_log2 = 8;
		pend_len = 0;
		pend_long = 0;
		pend_crc = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// The register comes out of reset at its widest setting.
		apb_cycle(0, '0, rd);
		if (rd[3:0] != 8) begin
			mismatches++;
			$display("bucket_count_log2 after reset %0d", rd[3:0]);
		end

		// Directed items: empty key, update, delete twice, long key, prefixes, odd sizes.
		rows.push_back(row(REQ_GET, '0, 0, 1, '0, 1, RS_FIND_MISS, '1, 0));
		rows.push_back(row(REQ_INSERT, '1, 0, 1, '0, 1, RS_INSERTED, '0, 1));
		rows.push_back(row(REQ_GET, '0, 0, 1, '1, 1, RS_FOUND, '0, 1));
		rows.push_back(row(REQ_INSERT, '0, 0, 1, '1, 1, RS_UPDATED, '0, 1));
		rows.push_back(row(REQ_GET, '0, 0, 1, '0, 1, RS_FOUND, '1, 1));
		rows.push_back(row(REQ_DELETE, '0, 0, 1, '0, 1, RS_DELETED, '0, 0));
		rows.push_back(row(REQ_DELETE, '0, 0, 1, '0, 1, RS_DEL_MISS, '0, 0));
		for (int i = 0; i < 8; i++)
			rows.push_back(row(REQ_INSERT, '1, 4, 0, '1, 0, RS_INSERTED, '0, 0));
		rows.push_back(row(REQ_INSERT, '1, 4, 1, '1, 1, RS_KEY_LONG, '0, 0));
		rows.push_back(row(REQ_INSERT, '1, 3, 1, 32'd5, 1, RS_INSERTED, '0, 1));
		rows.push_back(row(REQ_GET, '1, 7, 0, '0, 0, RS_INSERTED, '0, 0));
		rows.push_back(row(REQ_GET, '0, 2, 1, '0, 1, RS_FIND_MISS, '1, 1));
		rows.push_back(row(REQ_INSERT, '0, 3, 0, '0, 0, RS_INSERTED, '0, 0));
		rows.push_back(row(REQ_INSERT, '0, 4, 1, '0, 0, RS_INSERTED, '0, 0));
		rows.push_back(row(REQ_GET_ALT, '1, 3, 1, '0, 1, RS_FOUND, 32'd5, 2));
		rows.push_back(row(REQ_DELETE, 32'h00AB_CD12, 1, 1, '0, 0, RS_INSERTED, '0, 0));
		foreach (rows[i]) offer(rows[i].c, rows[i].typed, rows[i].a);

		// One chain for everything, with the receiver stalled for a long stretch.
		set_buckets(0);
		repeat (24) key_pool.push_back(random_key());
		hold_go <= 1;
		random_ops(300);

		// 128 buckets; the first part runs without any gaps.
		set_buckets(7);
		key_pool.delete();
		repeat (24) key_pool.push_back(random_key());
		quiet = 1;
		random_ops(200);
		quiet = 0;
		random_ops(250);

		// All buckets: fill the pool past its end, then churn through the free list.
		set_buckets(8);
		for (int i = 0; i < 270; i++) begin
			k.npre = 3;
			k.pre = {8'($urandom), 24'(i * 40503)};
			k.nw = 0;
			send_key(k, REQ_INSERT, $urandom);
			if (i % 3 == 0) key_pool.push_back(k);
		end
		random_ops(300);

		req_ch.valid <= 0;
		wait (answers_due.size() == 0);
		repeat (50) @(posedge clk);
		if (mismatches == 0)
			$display("tb_crc_chained_hash_table: clean");
		else
			$display("tb_crc_chained_hash_table: errors");
		$finish;
	end

endmodule
